// File: sv/spr_pkg.sv
// spr_pkg: shared types and fixed-point constants for the range-reduced sine block
// used by spr_front, spr_back and sine_polynomial_range_reduced_top; no dependencies

package spr_pkg;

	// pi as the single-precision value, held in Q3.40
	localparam logic [42:0] PI_Q40      = 43'd13176795 << 18;
	localparam logic [42:0] HALF_PI_Q40 = 43'd13176795 << 17;
	localparam logic [42:0] TWO_PI_Q40  = 43'd13176795 << 19;

	// 1/(2*pi) in Q0.32
	localparam logic [29:0] RECIP_2PI = 30'd683565257;

	// taylor coefficients in Q0.32
	localparam logic [29:0] COEF_A = 30'd715827904;
	localparam logic [25:0] COEF_B = 26'd35791396;
	localparam logic [19:0] COEF_G = 20'd852176;
	localparam logic [13:0] COEF_D = 14'd11836;

	localparam logic [30:0] ONE_Q30 = 31'd1 << 30;

	// word passed from the reduction front end to the polynomial back end
	typedef struct packed {
		logic        neg;   // final sign of the result
		logic [30:0] t30;   // folded angle in [0, pi/2], Q1.30
	} mid_t;

endpackage

// File: sv/sine_polynomial_range_reduced_top.sv
// sine_polynomial_range_reduced_top: Q8.24 angle in, Q2.30 sine out
// built from spr_front, spr_fifo and spr_back; uses spr_pkg
//
//   channel  | handshake      | word
//   ---------+----------------+-----------------------------
//   input    | push / full    | angle, signed Q8.24
//   result   | pop / empty    | sine_value, signed Q2.30
//
// one angle accepted per cycle while full is low; results leave in order, through
// five reduction stages, the queue and six polynomial stages, one multiplier each
// reset clears only valid bits, queue pointers and the queue count; no data is cleared
// a held result stalls the polynomial stages; the queue of QUEUE_DEPTH words then
// fills, and full rises only once the reduction stages are blocked too

module sine_polynomial_range_reduced_top #(
	parameter int QUEUE_DEPTH = 4   // 2 or more
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [31:0] angle,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] sine_value
);

	localparam int WORD_W = $bits(spr_pkg::mid_t);

	logic          front_ready;
	logic          front_valid;
	spr_pkg::mid_t front_word;
	logic          q_full;
	logic          q_empty;
	logic          back_ready;
	spr_pkg::mid_t q_word;
	logic          back_valid;

	spr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push),
		.in_ready  (front_ready),
		.angle     (angle),
		.out_valid (front_valid),
		.out_ready (!q_full),
		.out_word  (front_word)
	);

	spr_fifo #(
		.WIDTH (WORD_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (front_valid),
		.wdata  (front_word),
		.rd     (back_ready),
		.rdata  (q_word),
		.full   (q_full),
		.empty  (q_empty)
	);

	spr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (!q_empty),
		.in_ready   (back_ready),
		.in_word    (q_word),
		.out_valid  (back_valid),
		.out_ready  (pop),
		.sine_value (sine_value)
	);

	assign full  = !front_ready;
	assign empty = !back_valid;

endmodule

// File: sv/spr_fifo.sv
// spr_fifo: small synchronous queue whose full and empty flags are decoded from a registered count
// generic storage, no package dependency

module spr_fifo #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             rd,
	output logic [WIDTH-1:0] rdata,
	output logic             full,
	output logic             empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_wr;
	logic             do_rd;

	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign full  = (cnt_q == FULL_CNT);
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

endmodule

// File: sv/spr_front.sv
// spr_front: takes angles, reduces them modulo 2*pi and folds them into the first quadrant
// depends on spr_pkg for the pi constants and the mid_t word

module spr_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [31:0] angle,
	output logic               out_valid,
	input  logic               out_ready,
	output spr_pkg::mid_t      out_word
);

	logic        en;
	logic [31:0] raw;
	logic [31:0] mag;

	logic        v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [31:0] mag_s1, mag_s2;
	logic        neg_s1, neg_s2, neg_s3, neg_s4, neg_s5;
	logic [5:0]  k_s2;
	logic signed [49:0] d_s3;
	logic [42:0] r_s4;
	logic [30:0] t30_s5;

	logic [61:0] prod;
	logic [47:0] a40;
	logic [48:0] km;
	logic [49:0] d_nx;
	logic [49:0] r_wide;
	logic [42:0] t40;
	logic [42:0] t40_rnd;
	logic        neg_q;

	// whole front advances unless its last word is blocked by the queue
	assign en       = !v_s5 || out_ready;
	assign in_ready = en;

	assign raw = angle;
	assign mag = raw[31] ? (~raw + 32'd1) : raw;

	// quotient estimate from the reciprocal of 2*pi
	assign prod = mag_s1 * spr_pkg::RECIP_2PI;

	assign a40  = {mag_s2, 16'd0};
	assign km   = 49'(k_s2) * 49'(spr_pkg::TWO_PI_Q40);
	assign d_nx = 50'(a40) - 50'(km);

	// one correction each way makes the remainder land in [0, 2*pi)
	always_comb begin
		if (d_s3 < 0) begin
			r_wide = d_s3 + 50'(spr_pkg::TWO_PI_Q40);
		end else if (d_s3 >= 50'(spr_pkg::TWO_PI_Q40)) begin
			r_wide = d_s3 - 50'(spr_pkg::TWO_PI_Q40);
		end else begin
			r_wide = d_s3;
		end
	end

	// quadrant fold, boundaries go to the lower quadrant
	always_comb begin
		if (r_s4 <= spr_pkg::HALF_PI_Q40) begin
			t40   = r_s4;
			neg_q = 1'b0;
		end else if (r_s4 <= spr_pkg::PI_Q40) begin
			t40   = spr_pkg::PI_Q40 - r_s4;
			neg_q = 1'b0;
		end else if (r_s4 <= spr_pkg::PI_Q40 + spr_pkg::HALF_PI_Q40) begin
			t40   = r_s4 - spr_pkg::PI_Q40;
			neg_q = 1'b1;
		end else begin
			t40   = spr_pkg::TWO_PI_Q40 - r_s4;
			neg_q = 1'b1;
		end
	end

	assign t40_rnd = t40 + 43'd512;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= mag;
			neg_s1 <= raw[31];
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			k_s2   <= prod[61:56];
			d_s3   <= $signed(d_nx);
			neg_s3 <= neg_s2;
			r_s4   <= r_wide[42:0];
			neg_s4 <= neg_s3;
			t30_s5 <= t40_rnd[40:10];
			neg_s5 <= neg_s4 ^ neg_q;
		end
	end

	assign out_valid     = v_s5;
	assign out_word.neg  = neg_s5;
	assign out_word.t30  = t30_s5;

endmodule

// File: sv/spr_back.sv
// spr_back: evaluates the degree-9 odd taylor polynomial in horner form and applies the sign
// depends on spr_pkg for the coefficients and the mid_t word

module spr_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  spr_pkg::mid_t       in_word,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  sine_value
);

	// a*b rounded half up, result in the format of the term
	function automatic logic [33:0] mul_q30(input logic [31:0] a, input logic [31:0] b);
		logic [64:0] p;
		p = 65'(a) * 65'(b) + 65'(64'd1 << 29);
		return p[63:30];
	endfunction

	logic        en;

	logic        v_b1, v_b2, v_b3, v_b4, v_b5, v_b6;
	logic [30:0] t30_b1, t30_b2, t30_b3, t30_b4, t30_b5;
	logic        neg_b1, neg_b2, neg_b3, neg_b4, neg_b5;
	logic [31:0] x2_b1, x2_b2, x2_b3, x2_b4;
	logic [19:0] t1_b2;
	logic [25:0] t2_b3;
	logic [29:0] t3_b4;
	logic [32:0] t4_b5;
	logic [31:0] y_b6;

	logic [33:0] x2_nx;
	logic [33:0] m1, m2, m3, m4;
	logic [64:0] yp;
	logic [32:0] y_raw;
	logic [30:0] y_sat;

	assign en       = !v_b6 || out_ready;
	assign in_ready = en;

	assign x2_nx = mul_q30({1'b0, in_word.t30}, {1'b0, in_word.t30});
	assign m1    = mul_q30(32'(spr_pkg::COEF_D), x2_b1);
	assign m2    = mul_q30(x2_b2, 32'(t1_b2));
	assign m3    = mul_q30(x2_b3, 32'(t2_b3));
	assign m4    = mul_q30(x2_b4, 32'(t3_b4));

	// final product back to Q2.30, saturated at one near pi/2
	assign yp    = 65'(t30_b5) * 65'(t4_b5) + 65'(64'd1 << 31);
	assign y_raw = yp[64:32];
	assign y_sat = (y_raw > 33'(spr_pkg::ONE_Q30)) ? spr_pkg::ONE_Q30 : y_raw[30:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_b1 <= 1'b0;
			v_b2 <= 1'b0;
			v_b3 <= 1'b0;
			v_b4 <= 1'b0;
			v_b5 <= 1'b0;
			v_b6 <= 1'b0;
		end else if (en) begin
			v_b1 <= in_valid;
			v_b2 <= v_b1;
			v_b3 <= v_b2;
			v_b4 <= v_b3;
			v_b5 <= v_b4;
			v_b6 <= v_b5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t30_b1 <= in_word.t30;
			neg_b1 <= in_word.neg;
			x2_b1  <= x2_nx[31:0];

			t30_b2 <= t30_b1;
			neg_b2 <= neg_b1;
			x2_b2  <= x2_b1;
			t1_b2  <= 20'(34'(spr_pkg::COEF_G) - m1);

			t30_b3 <= t30_b2;
			neg_b3 <= neg_b2;
			x2_b3  <= x2_b2;
			t2_b3  <= 26'(34'(spr_pkg::COEF_B) - m2);

			t30_b4 <= t30_b3;
			neg_b4 <= neg_b3;
			x2_b4  <= x2_b3;
			t3_b4  <= 30'(34'(spr_pkg::COEF_A) - m3);

			t30_b5 <= t30_b4;
			neg_b5 <= neg_b4;
			t4_b5  <= 33'((34'd1 << 32) - m4);

			y_b6   <= neg_b5 ? (32'd0 - 32'(y_sat)) : 32'(y_sat);
		end
	end

	assign out_valid  = v_b6;
	assign sine_value = $signed(y_b6);

endmodule
